FILE: rtl/core/dpc_pkg.sv
// Shared constants, register indexes and reset table for the demura pixel correction block.
// No dependencies; compile first.
`default_nettype none

package dpc_pkg;

   localparam int unsigned DefaultChannelBits = 8;
   localparam int unsigned DefaultKnotCount   = 5;
   localparam int unsigned MaxChannelBits     = 12;
   localparam int unsigned ChannelCount       = 3;
   localparam int unsigned CtrlLimit          = 64;

   localparam int unsigned RegEnable   = 0;
   localparam int unsigned RegKnotBase = 1;

   localparam logic [MaxChannelBits-1:0] KnotResetTab [8] = '{
      12'd32, 12'd64, 12'd128, 12'd192, 12'd224, 12'd255, 12'd255, 12'd255
   };

   function automatic logic [MaxChannelBits-1:0] knot_reset_value(input int unsigned idx);
      return KnotResetTab[idx[2:0]];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dpc_if.sv
// Valid/ready stream interfaces for pixel request and corrected response words.
// Depends on dpc_pkg for default widths.
`default_nettype none

interface dpc_req_if #(
   parameter int unsigned CHANNEL_BITS = dpc_pkg::DefaultChannelBits,
   parameter int unsigned KNOT_COUNT   = dpc_pkg::DefaultKnotCount
);
   logic                                 valid;
   logic                                 ready;
   logic [CHANNEL_BITS-1:0]              in_red;
   logic [CHANNEL_BITS-1:0]              in_green;
   logic [CHANNEL_BITS-1:0]              in_blue;
   logic [KNOT_COUNT*CHANNEL_BITS-1:0]   ctrl_red;
   logic [KNOT_COUNT*CHANNEL_BITS-1:0]   ctrl_green;
   logic [KNOT_COUNT*CHANNEL_BITS-1:0]   ctrl_blue;

   modport source (output valid, in_red, in_green, in_blue, ctrl_red, ctrl_green, ctrl_blue,
                   input ready);
   modport sink   (input valid, in_red, in_green, in_blue, ctrl_red, ctrl_green, ctrl_blue,
                   output ready);
endinterface

interface dpc_rsp_if #(
   parameter int unsigned CHANNEL_BITS = dpc_pkg::DefaultChannelBits
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dpc_csr.sv
// APB-style register file: correction enable and knot positions.
// Depends on dpc_pkg for register indexes and knot reset values.
`default_nettype none

module dpc_csr #(
   parameter int unsigned CHANNEL_BITS = dpc_pkg::DefaultChannelBits,
   parameter int unsigned KNOT_COUNT   = dpc_pkg::DefaultKnotCount,
   parameter int unsigned ADDR_BITS    = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [ADDR_BITS-1:0]                    paddr,
   input  logic [31:0]                             pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready,
   output logic                                    correction_enable,
   output logic [KNOT_COUNT-1:0][CHANNEL_BITS-1:0] knot
);
   import dpc_pkg::*;

   localparam int unsigned IdxBits = ADDR_BITS - 2;

   logic                                    enable_ff;
   logic [KNOT_COUNT-1:0][CHANNEL_BITS-1:0] knot_ff;
   logic                                    wr;
   logic [IdxBits-1:0]                      idx;

   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[ADDR_BITS-1:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (wr && idx == IdxBits'(RegEnable)) begin
         enable_ff <= pwdata[0];
      end
   end

   for (genvar i = 0; i < KNOT_COUNT; i++) begin : g_knot
      localparam logic [MaxChannelBits-1:0] ResetWide = knot_reset_value(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            knot_ff[i] <= ResetWide[CHANNEL_BITS-1:0];
         end else if (wr && idx == IdxBits'(RegKnotBase + i)) begin
            knot_ff[i] <= pwdata[CHANNEL_BITS-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (idx == IdxBits'(RegEnable)) begin
         prdata[0] = enable_ff;
      end
      for (int i = 0; i < KNOT_COUNT; i++) begin
         if (idx == IdxBits'(RegKnotBase + i)) begin
            prdata[CHANNEL_BITS-1:0] = knot_ff[i];
         end
      end
   end

   assign correction_enable = enable_ff;
   assign knot              = knot_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dpc_front.sv
// Front pipeline: segment selection stage, then weight multiply stage, three channels.
// Depends on dpc_pkg for the control word bit limit.
`default_nettype none

module dpc_front #(
   parameter int unsigned CHANNEL_BITS = dpc_pkg::DefaultChannelBits,
   parameter int unsigned KNOT_COUNT   = dpc_pkg::DefaultKnotCount
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            correction_enable,
   input  logic [KNOT_COUNT-1:0][CHANNEL_BITS-1:0]         knot,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [2:0][CHANNEL_BITS-1:0]                    pixel,
   input  logic [2:0][KNOT_COUNT*CHANNEL_BITS-1:0]         ctrl,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output logic [2:0][2*CHANNEL_BITS-1:0]                  prod_lo,
   output logic [2:0][2*CHANNEL_BITS-1:0]                  prod_hi,
   output logic [2:0][CHANNEL_BITS-1:0]                    span,
   output logic [2:0]                                      bypass,
   output logic [2:0][CHANNEL_BITS-1:0]                    bypass_val
);
   import dpc_pkg::*;

   localparam int unsigned CtrlBits = KNOT_COUNT * CHANNEL_BITS;
   localparam int unsigned ProdBits = 2 * CHANNEL_BITS;
   localparam logic [CHANNEL_BITS-1:0] LevelMax = '1;

   logic                                 v1_ff;
   logic                                 v2_ff;
   logic                                 open1;
   logic                                 open2;

   logic [2:0][CHANNEL_BITS-1:0]         x1_ff;
   logic [2:0][CHANNEL_BITS-1:0]         xl1_ff;
   logic [2:0][CHANNEL_BITS-1:0]         yl1_ff;
   logic [2:0][CHANNEL_BITS-1:0]         xh1_ff;
   logic [2:0][CHANNEL_BITS-1:0]         yh1_ff;
   logic [2:0]                           byp1_ff;
   logic [2:0][CHANNEL_BITS-1:0]         bval1_ff;

   logic [2:0][ProdBits-1:0]             lo2_ff;
   logic [2:0][ProdBits-1:0]             hi2_ff;
   logic [2:0][CHANNEL_BITS-1:0]         d2_ff;
   logic [2:0]                           byp2_ff;
   logic [2:0][CHANNEL_BITS-1:0]         bval2_ff;

   assign open2    = !v2_ff || out_ready;
   assign open1    = !v1_ff || open2;
   assign in_ready = open1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (open1) begin
            v1_ff <= in_valid;
         end
         if (open2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [CtrlBits-1:0]     ctrl_eff;
      logic [CHANNEL_BITS-1:0] xl_in;
      logic [CHANNEL_BITS-1:0] yl_in;
      logic [CHANNEL_BITS-1:0] xh_in;
      logic [CHANNEL_BITS-1:0] yh_in;
      logic                    byp_in;
      logic [CHANNEL_BITS-1:0] bval_in;
      logic [CHANNEL_BITS-1:0] run_hi;
      logic [CHANNEL_BITS-1:0] run_lo;
      logic [ProdBits-1:0]     lo_in;
      logic [ProdBits-1:0]     hi_in;

      for (genvar j = 0; j < CtrlBits; j++) begin : g_bit
         if (j < CtrlLimit) begin : g_keep
            assign ctrl_eff[j] = ctrl[c][j];
         end else begin : g_drop
            assign ctrl_eff[j] = 1'b0;
         end
      end

      always_comb begin
         logic found;
         found = 1'b0;
         xl_in = '0;
         yl_in = '0;
         xh_in = LevelMax;
         yh_in = LevelMax;
         for (int i = 0; i < KNOT_COUNT; i++) begin
            if (!found && pixel[c] < knot[i]) begin
               xh_in = knot[i];
               yh_in = ctrl_eff[i*CHANNEL_BITS +: CHANNEL_BITS];
               found = 1'b1;
            end else if (!found) begin
               xl_in = knot[i];
               yl_in = ctrl_eff[i*CHANNEL_BITS +: CHANNEL_BITS];
            end
         end
         byp_in  = !correction_enable || (xh_in <= xl_in);
         bval_in = correction_enable ? yh_in : pixel[c];
      end

      always_ff @(posedge clock) begin
         if (open1 && in_valid) begin
            x1_ff[c]    <= pixel[c];
            xl1_ff[c]   <= xl_in;
            yl1_ff[c]   <= yl_in;
            xh1_ff[c]   <= xh_in;
            yh1_ff[c]   <= yh_in;
            byp1_ff[c]  <= byp_in;
            bval1_ff[c] <= bval_in;
         end
      end

      assign run_hi = xh1_ff[c] - x1_ff[c];
      assign run_lo = x1_ff[c] - xl1_ff[c];
      assign lo_in  = ProdBits'(yl1_ff[c]) * ProdBits'(run_hi);
      assign hi_in  = ProdBits'(yh1_ff[c]) * ProdBits'(run_lo);

      always_ff @(posedge clock) begin
         if (open2 && v1_ff) begin
            lo2_ff[c]   <= lo_in;
            hi2_ff[c]   <= hi_in;
            d2_ff[c]    <= xh1_ff[c] - xl1_ff[c];
            byp2_ff[c]  <= byp1_ff[c];
            bval2_ff[c] <= bval1_ff[c];
         end
      end
   end

   assign out_valid  = v2_ff;
   assign prod_lo    = lo2_ff;
   assign prod_hi    = hi2_ff;
   assign span       = d2_ff;
   assign bypass     = byp2_ff;
   assign bypass_val = bval2_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dpc_divide.sv
// Rounding divider pipeline: numerator stage, then one restoring quotient bit per stage.
// No package dependencies.
`default_nettype none

module dpc_divide #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [2:0][2*CHANNEL_BITS-1:0]     prod_lo,
   input  logic [2:0][2*CHANNEL_BITS-1:0]     prod_hi,
   input  logic [2:0][CHANNEL_BITS-1:0]       span,
   input  logic [2:0]                         bypass,
   input  logic [2:0][CHANNEL_BITS-1:0]       bypass_val,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [2:0][CHANNEL_BITS-1:0]       result
);

   localparam int unsigned NumBits = 2 * CHANNEL_BITS + 2;
   localparam int unsigned Stages  = CHANNEL_BITS + 1;

   logic [Stages-1:0]       v_ff;
   logic [Stages:0]         open_w;
   logic [NumBits-1:0]      rem_ff  [Stages][3];
   logic [CHANNEL_BITS:0]   den_ff  [Stages][3];
   logic [CHANNEL_BITS-1:0] quot_ff [Stages][3];
   logic [2:0]              byp_ff  [Stages];
   logic [CHANNEL_BITS-1:0] bval_ff [Stages][3];

   assign open_w[Stages] = out_ready;
   assign in_ready       = open_w[0];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      assign open_w[s] = !v_ff[s] || open_w[s+1];

      if (s == 0) begin : g_num
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (open_w[s]) begin
               v_ff[s] <= in_valid;
            end
         end

         for (genvar c = 0; c < 3; c++) begin : g_chan
            logic [2*CHANNEL_BITS:0] sum;
            assign sum = {1'b0, prod_lo[c]} + {1'b0, prod_hi[c]};

            always_ff @(posedge clock) begin
               if (open_w[s] && in_valid) begin
                  rem_ff[s][c]  <= {sum, 1'b0} + NumBits'(span[c]);
                  den_ff[s][c]  <= {span[c], 1'b0};
                  quot_ff[s][c] <= '0;
                  byp_ff[s][c]  <= bypass[c];
                  bval_ff[s][c] <= bypass_val[c];
               end
            end
         end
      end else begin : g_bit
         localparam int unsigned Shift = CHANNEL_BITS - s;

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (open_w[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end

         for (genvar c = 0; c < 3; c++) begin : g_chan
            logic [NumBits-1:0]      shifted;
            logic [NumBits:0]        trial;
            logic [NumBits-1:0]      rem_in;
            logic [CHANNEL_BITS-1:0] quot_in;

            assign shifted = NumBits'(den_ff[s-1][c]) << Shift;
            assign trial   = {1'b0, rem_ff[s-1][c]} - {1'b0, shifted};

            always_comb begin
               rem_in  = rem_ff[s-1][c];
               quot_in = quot_ff[s-1][c];
               if (!trial[NumBits]) begin
                  rem_in         = trial[NumBits-1:0];
                  quot_in[Shift] = 1'b1;
               end
            end

            always_ff @(posedge clock) begin
               if (open_w[s] && v_ff[s-1]) begin
                  rem_ff[s][c]  <= rem_in;
                  den_ff[s][c]  <= den_ff[s-1][c];
                  quot_ff[s][c] <= quot_in;
                  byp_ff[s][c]  <= byp_ff[s-1][c];
                  bval_ff[s][c] <= bval_ff[s-1][c];
               end
            end
         end
      end
   end

   assign out_valid = v_ff[Stages-1];

   for (genvar c = 0; c < 3; c++) begin : g_out
      assign result[c] = byp_ff[Stages-1][c] ? bval_ff[Stages-1][c] : quot_ff[Stages-1][c];
   end

endmodule

`default_nettype wire

FILE: rtl/core/demura_pixel_correction.sv
// Top level of the demura pixel correction block: registers, front pipeline, divider pipeline.
// Depends on dpc_pkg, dpc_if, dpc_csr, dpc_front and dpc_divide.
//
//   port group   direction  handshake             carries
//   req_ch       in         valid/ready           pixel levels and control points
//   rsp_ch       out        valid/ready           corrected pixel levels
//   APB (p*)     in         psel/penable, pready  enable and knot registers
//
// The pipeline has two front stages, a numerator stage and one stage per quotient bit
// of the restoring divider. One word enters per clock unless a stall on rsp_ch backs up.
// Synchronous reset clears valid bits and loads register defaults; no clearing pass.
// A stall on rsp_ch holds only the occupied stages; empty stages keep taking words.
`default_nettype none

module demura_pixel_correction #(
   parameter int unsigned CHANNEL_BITS = dpc_pkg::DefaultChannelBits,
   parameter int unsigned KNOT_COUNT   = dpc_pkg::DefaultKnotCount
) (
   input  logic                                      clock,
   input  logic                                      reset,
   dpc_req_if.sink                                   req_ch,
   dpc_rsp_if.source                                 rsp_ch,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [$clog2(4*(KNOT_COUNT+1))-1:0]       paddr,
   input  logic [31:0]                               pwdata,
   output logic [31:0]                               prdata,
   output logic                                      pready
);

   localparam int unsigned AddrBits = $clog2(4 * (KNOT_COUNT + 1));

   logic                                    correction_enable;
   logic [KNOT_COUNT-1:0][CHANNEL_BITS-1:0] knot;
   logic [2:0][CHANNEL_BITS-1:0]            pixel;
   logic [2:0][KNOT_COUNT*CHANNEL_BITS-1:0] ctrl;
   logic                                    mid_valid;
   logic                                    mid_ready;
   logic [2:0][2*CHANNEL_BITS-1:0]          prod_lo;
   logic [2:0][2*CHANNEL_BITS-1:0]          prod_hi;
   logic [2:0][CHANNEL_BITS-1:0]            span;
   logic [2:0]                              bypass;
   logic [2:0][CHANNEL_BITS-1:0]            bypass_val;
   logic [2:0][CHANNEL_BITS-1:0]            result;

   assign pixel = {req_ch.in_blue, req_ch.in_green, req_ch.in_red};
   assign ctrl  = {req_ch.ctrl_blue, req_ch.ctrl_green, req_ch.ctrl_red};

   dpc_csr #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .KNOT_COUNT   (KNOT_COUNT),
      .ADDR_BITS    (AddrBits)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .correction_enable (correction_enable),
      .knot              (knot)
   );

   dpc_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .KNOT_COUNT   (KNOT_COUNT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .correction_enable (correction_enable),
      .knot              (knot),
      .in_valid          (req_ch.valid),
      .in_ready          (req_ch.ready),
      .pixel             (pixel),
      .ctrl              (ctrl),
      .out_valid         (mid_valid),
      .out_ready         (mid_ready),
      .prod_lo           (prod_lo),
      .prod_hi           (prod_hi),
      .span              (span),
      .bypass            (bypass),
      .bypass_val        (bypass_val)
   );

   dpc_divide #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .prod_lo    (prod_lo),
      .prod_hi    (prod_hi),
      .span       (span),
      .bypass     (bypass),
      .bypass_val (bypass_val),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .result     (result)
   );

   assign rsp_ch.out_red   = result[0];
   assign rsp_ch.out_green = result[1];
   assign rsp_ch.out_blue  = result[2];

endmodule

`default_nettype wire

FILE: rtl/core/dpc_checker.sv
// Port-level checks for demura_pixel_correction, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none

module dpc_checker #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [CHANNEL_BITS-1:0] out_red,
   input  logic [CHANNEL_BITS-1:0] out_green,
   input  logic [CHANNEL_BITS-1:0] out_blue
);

   localparam int unsigned Depth     = CHANNEL_BITS + 3;
   localparam int unsigned CountBits = $clog2(Depth + 2);

   logic [CountBits-1:0] inflight_ff;
   logic [CountBits-1:0] inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready) begin
         inflight_in = inflight_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         inflight_in = inflight_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
      else $error("response word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response word without an accepted request word");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CountBits'(Depth))
      else $error("more words in flight than pipeline stages");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side blocked while response side is open");

endmodule

bind demura_pixel_correction dpc_checker #(
   .CHANNEL_BITS (CHANNEL_BITS)
) u_dpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_red   (rsp_ch.out_red),
   .out_green (rsp_ch.out_green),
   .out_blue  (rsp_ch.out_blue)
);

`default_nettype wire

FILE: sim/tb_demura_pixel_correction.sv
// Self-checking testbench for demura_pixel_correction: streams pixels through the block,
// predicts each corrected pixel and compares it field by field. Needs dpc_pkg, dpc_if and the RTL.
`default_nettype none

module tb_demura_pixel_correction;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CB = dpc_pkg::DefaultChannelBits;
   localparam int unsigned KC = dpc_pkg::DefaultKnotCount;
   localparam int unsigned AW = $clog2(4*(KC+1));
   localparam longint unsigned LEVEL_MAX = (64'd1 << CB) - 1;
   localparam int unsigned LATENCY = CB + 3;

   typedef struct packed {
      logic [CB-1:0]    red;
      logic [CB-1:0]    green;
      logic [CB-1:0]    blue;
      logic [KC*CB-1:0] ctrl_red;
      logic [KC*CB-1:0] ctrl_green;
      logic [KC*CB-1:0] ctrl_blue;
   } pixel_type;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
   } level_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          psel;
   logic          penable;
   logic          pwrite;
   logic [AW-1:0] paddr;
   logic [31:0]   pwdata;
   logic [31:0]   prdata;
   logic          pready;

   dpc_req_if #(.CHANNEL_BITS(CB), .KNOT_COUNT(KC)) req_ch ();
   dpc_rsp_if #(.CHANNEL_BITS(CB))                  rsp_ch ();

   demura_pixel_correction #(.CHANNEL_BITS(CB), .KNOT_COUNT(KC)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic          corr_on;
   logic [CB-1:0] knot_pos [KC];

   pixel_type   pending_q [$];
   level_type   corrected_q [$];
   pixel_type   cur_pixel;
   bit          gaps_on;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned err_cnt;
   int unsigned n_words;
   int unsigned n_checked;
   int unsigned n_csr;
   int unsigned n_settings;

   always #1 clock = ~clock;

   function automatic logic [CB-1:0] map_level(logic [CB-1:0] x, logic [KC*CB-1:0] ctrl);
      longint unsigned lo_x, lo_y, hi_x, hi_y, span, num, y;
      bit found;
      lo_x = 0;
      lo_y = 0;
      hi_x = LEVEL_MAX;
      hi_y = LEVEL_MAX;
      found = 1'b0;
      for (int i = 0; i < KC; i++) begin
         if (!found && x < knot_pos[i]) begin
            hi_x = knot_pos[i];
            hi_y = ctrl[i*CB +: CB];
            found = 1'b1;
         end else if (!found) begin
            lo_x = knot_pos[i];
            lo_y = ctrl[i*CB +: CB];
         end
      end
      if (hi_x <= lo_x)
         return CB'(hi_y);
      span = hi_x - lo_x;
      num = lo_y * (hi_x - x) + hi_y * (x - lo_x);
      y = (2 * num + span) / (2 * span);
      if (y > LEVEL_MAX)
         y = LEVEL_MAX;
      return CB'(y);
   endfunction

   function automatic level_type correct_pixel(pixel_type p);
      level_type r;
      if (corr_on) begin
         r.red   = map_level(p.red,   p.ctrl_red);
         r.green = map_level(p.green, p.ctrl_green);
         r.blue  = map_level(p.blue,  p.ctrl_blue);
      end else begin
         r.red   = p.red;
         r.green = p.green;
         r.blue  = p.blue;
      end
      return r;
   endfunction

   // favour the ends of the range and the neighbourhood of the knots
   function automatic logic [CB-1:0] pick_level();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = int'(LEVEL_MAX);
         2, 3: begin
            v = int'(knot_pos[$urandom_range(0, KC-1)]) + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
               v = 0;
            if (v > int'(LEVEL_MAX))
               v = int'(LEVEL_MAX);
         end
         default: v = int'($urandom_range(0, int'(LEVEL_MAX)));
      endcase
      return CB'(v);
   endfunction

   function automatic logic [KC*CB-1:0] pick_ctrl();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return w[KC*CB-1:0];
      endcase
   endfunction

   task automatic add_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b, input logic [KC*CB-1:0] cr,
                            input logic [KC*CB-1:0] cg, input logic [KC*CB-1:0] cbl);
      pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.ctrl_red = cr;
      p.ctrl_green = cg;
      p.ctrl_blue = cbl;
      pending_q.push_back(p);
   endtask

   task automatic add_random(input int unsigned n);
      for (int i = 0; i < n; i++)
         add_pixel(pick_level(), pick_level(), pick_level(), pick_ctrl(), pick_ctrl(),
                   pick_ctrl());
   endtask

   // sample between edges so that every update of the edge has settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_ch.valid || corrected_q.size() != 0);
   endtask

   task automatic csr_write(input int unsigned idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AW'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == dpc_pkg::RegEnable)
         corr_on = value[0];
      else if (idx >= dpc_pkg::RegKnotBase && idx < dpc_pkg::RegKnotBase + KC)
         knot_pos[idx - dpc_pkg::RegKnotBase] = value[CB-1:0];
      n_csr++;
   endtask

   task automatic load_knots(input int unsigned k [KC]);
      logic [31:0] noise;
      for (int i = 0; i < KC; i++) begin
         noise = $urandom;
         csr_write(dpc_pkg::RegKnotBase + i, {noise[23:0], 8'h00} | 32'(k[i]));
      end
      n_settings++;
   endtask

   task automatic random_knots(input bit sorted);
      int unsigned vals [$];
      int unsigned k [KC];
      for (int i = 0; i < KC; i++)
         vals.push_back($urandom_range(0, int'(LEVEL_MAX)));
      if (sorted)
         vals.sort();
      for (int i = 0; i < KC; i++)
         k[i] = vals[i];
      load_knots(k);
   endtask

   // hold the word while the block stalls it; otherwise record the accepted one and advance
   always @(posedge clock) begin
      if (!reset && !(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid) begin
            corrected_q.push_back(correct_pixel(cur_pixel));
            n_words++;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 11);
            req_ch.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            cur_pixel = pending_q.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.in_red     <= cur_pixel.red;
            req_ch.in_green   <= cur_pixel.green;
            req_ch.in_blue    <= cur_pixel.blue;
            req_ch.ctrl_red   <= cur_pixel.ctrl_red;
            req_ch.ctrl_green <= cur_pixel.ctrl_green;
            req_ch.ctrl_blue  <= cur_pixel.ctrl_blue;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      level_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (corrected_q.size() == 0) begin
               $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time,
                        rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue);
               err_cnt++;
            end else begin
               want = corrected_q.pop_front();
               n_checked++;
               if (rsp_ch.out_red !== want.red) begin
                  $display("%0t: out_red expected %0d got %0d", $time, want.red,
                           rsp_ch.out_red);
                  err_cnt++;
               end
               if (rsp_ch.out_green !== want.green) begin
                  $display("%0t: out_green expected %0d got %0d", $time, want.green,
                           rsp_ch.out_green);
                  err_cnt++;
               end
               if (rsp_ch.out_blue !== want.blue) begin
                  $display("%0t: out_blue expected %0d got %0d", $time, want.blue,
                           rsp_ch.out_blue);
                  err_cnt++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.in_red = '0;
      req_ch.in_green = '0;
      req_ch.in_blue = '0;
      req_ch.ctrl_red = '0;
      req_ch.ctrl_green = '0;
      req_ch.ctrl_blue = '0;
      rsp_ch.ready = 1'b0;
      gaps_on = 1'b1;
      req_gap = 0;
      rsp_stall = 0;
      err_cnt = 0;
      n_words = 0;
      n_checked = 0;
      n_csr = 0;
      n_settings = 1;
      corr_on = 1'b1;
      for (int i = 0; i < KC; i++)
         knot_pos[i] = CB'(dpc_pkg::knot_reset_value(i));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset knots
      add_pixel(0, 0, 0, '0, '0, '0);
      add_pixel(255, 255, 255, '1, '1, '1);
      add_pixel(31, 32, 33, 40'h00FF00FF00, 40'hFF00FF00FF, 40'h8040201008);
      add_pixel(63, 64, 65, '1, '0, 40'h0123456789);
      add_pixel(127, 128, 129, 40'hFEDCBA9876, 40'h5555555555, 40'hAAAAAAAAAA);
      add_pixel(191, 192, 193, 40'h1020304050, 40'hF0E0D0C0B0, 40'h7F80017F80);
      add_pixel(223, 224, 225, 40'h00000000FF, 40'hFF00000000, 40'h0000FF0000);
      add_pixel(254, 1, 128, 40'hC3A55A3C96, 40'h0F0F0F0F0F, 40'hF0F0F0F0F0);
      add_random(220);
      wait_idle();

      // pass-through, upper data bits set
      csr_write(dpc_pkg::RegEnable, 32'hFFFF_FFFE);
      n_settings++;
      add_random(150);
      wait_idle();

      csr_write(dpc_pkg::RegEnable, 32'h0000_0003);
      load_knots('{0, 0, 0, 0, 0});
      add_pixel(0, 1, 255, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_pixel(128, 254, 0, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_random(120);
      wait_idle();

      // top knot at full scale: full-scale input hits a zero-width segment
      load_knots('{255, 255, 255, 255, 255});
      add_pixel(255, 254, 0, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_pixel(255, 255, 255, '0, '0, '0);
      add_random(120);
      wait_idle();

      load_knots('{200, 10, 150, 10, 90});
      csr_write(dpc_pkg::RegKnotBase + KC, 32'h0000_0077);
      csr_write(dpc_pkg::RegKnotBase + KC + 1, 32'hFFFF_FFFF);
      add_pixel(5, 10, 100, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_pixel(199, 200, 255, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_pixel(9, 11, 149, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_pixel(151, 89, 91, pick_ctrl(), pick_ctrl(), pick_ctrl());
      add_random(150);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         gaps_on = (ph != 2);
         random_knots(ph[0] == 1'b0);
         add_random(150);
         wait_idle();
      end

      // closing stretch at full rate
      gaps_on = 1'b0;
      random_knots(1'b1);
      add_random(150);
      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d of %0d pixel words across %0d knot/enable settings",
               n_checked, n_words, n_settings);
      $display("(%0d register writes, pass-through, zero-width and unsorted knots)", n_csr);
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
